[rtl/fss_pkg.sv]
// shared types and constants for the frequency sort block
package fss_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int CNT_W       = 7;
  localparam int SYM_W       = 8;

  // one table entry: count in the upper bits, symbol in the lower bits
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SYM_W-1:0] sym;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             drop;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SORT_INIT,
    ST_SORT_LD,
    ST_SORT_GET,
    ST_SORT_RUN,
    ST_EMIT_LD,
    ST_EMIT_GET,
    ST_EMIT_OUT
  } fss_state_t;

endpackage

[rtl/fss_table.sv]
// symbol/count table: one write port, one registered read port
module fss_table import fss_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

[rtl/fss_out_reg.sv]
// output register holding one result item toward the master side
module fss_out_reg import fss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  out_item_t        push_item,
  output logic             push_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [SYM_W-1:0] m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  logic      valid;
  out_item_t item;

  assign push_ready = !valid || m_tready;
  assign m_tvalid   = valid;
  assign m_tdata    = item.sym;
  assign m_tlast    = item.last;
  assign m_tuser    = item.drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item <= push_item;
    end
  end

endmodule

[rtl/fss_engine.sv]
// sequencer: table search per byte, exchange sort and emission over the table memory
module fss_engine import fss_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [SYM_W-1:0] s_tdata,
  input  logic             s_tlast,
  output mem_req_t         mem_req,
  input  entry_t           rdata,
  output logic             push,
  output out_item_t        push_item,
  input  logic             push_ready
);

  fss_state_t        state, state_next;
  logic [SYM_W-1:0]  sym_q, sym_q_next;
  logic              last_q, last_q_next;
  logic [CNT_W-1:0]  distinct_total, distinct_total_next;
  logic [CNT_W-1:0]  length_seen, length_seen_next;
  logic              overflow_flag, overflow_flag_next;
  logic [CNT_W-1:0]  rk, rk_next;
  logic [ADDR_W-1:0] ck, ck_next;
  logic              pend, pend_next;
  logic [CNT_W-1:0]  idx, idx_next;
  entry_t            cur, cur_next;
  logic [CNT_W-1:0]  rem, rem_next;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_inc2;
  logic              last_entry;

  assign idx_inc    = idx + CNT_W'(1);
  assign idx_inc2   = idx + CNT_W'(2);
  assign last_entry = (idx_inc == distinct_total);

  always_comb begin
    state_next          = state;
    sym_q_next          = sym_q;
    last_q_next         = last_q;
    distinct_total_next = distinct_total;
    length_seen_next    = length_seen;
    overflow_flag_next  = overflow_flag;
    rk_next             = rk;
    ck_next             = ck;
    pend_next           = pend;
    idx_next            = idx;
    cur_next            = cur;
    rem_next            = rem;
    mem_req             = '0;
    push                = 1'b0;
    push_item           = '0;
    s_tready            = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          sym_q_next  = s_tdata;
          last_q_next = s_tlast;
          if (s_tdata != '0 && length_seen < CNT_W'(MAX_LEN)) begin
            length_seen_next = length_seen + CNT_W'(1);
            rk_next          = '0;
            pend_next        = 1'b0;
            state_next       = ST_SCAN;
          end else begin
            if (s_tdata != '0) begin
              overflow_flag_next = 1'b1;
            end
            if (s_tlast) begin
              state_next = ST_SORT_INIT;
            end
          end
        end
      end

      // reads stream one per cycle, each compare runs on the registered read data in the cycle after its read
      ST_SCAN: begin
        if (pend && rdata.sym == sym_q) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ck;
          mem_req.wdata = '{cnt: rdata.cnt + CNT_W'(1), sym: sym_q};
          state_next    = last_q ? ST_SORT_INIT : ST_IDLE;
        end else if (!pend && rk >= distinct_total) begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = distinct_total[ADDR_W-1:0];
          mem_req.wdata       = '{cnt: CNT_W'(1), sym: sym_q};
          distinct_total_next = distinct_total + CNT_W'(1);
          state_next          = last_q ? ST_SORT_INIT : ST_IDLE;
        end else if (rk < distinct_total) begin
          mem_req.raddr = rk[ADDR_W-1:0];
          ck_next       = rk[ADDR_W-1:0];
          rk_next       = rk + CNT_W'(1);
          pend_next     = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end

      ST_SORT_INIT: begin
        idx_next = '0;
        if (distinct_total == '0) begin
          length_seen_next   = '0;
          overflow_flag_next = 1'b0;
          state_next         = ST_IDLE;
        end else if (distinct_total == CNT_W'(1)) begin
          state_next = ST_EMIT_LD;
        end else begin
          state_next = ST_SORT_LD;
        end
      end

      ST_SORT_LD: begin
        mem_req.raddr = idx[ADDR_W-1:0];
        state_next    = ST_SORT_GET;
      end

      ST_SORT_GET: begin
        cur_next      = rdata;
        mem_req.raddr = idx_inc[ADDR_W-1:0];
        ck_next       = idx_inc[ADDR_W-1:0];
        rk_next       = idx_inc2;
        pend_next     = 1'b1;
        state_next    = ST_SORT_RUN;
      end

      // entry i lives in cur; a smaller count at j swaps into cur
      ST_SORT_RUN: begin
        if (pend) begin
          if (cur.cnt > rdata.cnt) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ck;
            mem_req.wdata = cur;
            cur_next      = rdata;
          end
          if (rk < distinct_total) begin
            mem_req.raddr = rk[ADDR_W-1:0];
            ck_next       = rk[ADDR_W-1:0];
            rk_next       = rk + CNT_W'(1);
            pend_next     = 1'b1;
          end else begin
            pend_next = 1'b0;
          end
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = idx[ADDR_W-1:0];
          mem_req.wdata = cur;
          if (idx_inc2 < distinct_total) begin
            idx_next   = idx_inc;
            state_next = ST_SORT_LD;
          end else begin
            idx_next   = '0;
            state_next = ST_EMIT_LD;
          end
        end
      end

      ST_EMIT_LD: begin
        mem_req.raddr = idx[ADDR_W-1:0];
        state_next    = ST_EMIT_GET;
      end

      ST_EMIT_GET: begin
        cur_next   = rdata;
        rem_next   = rdata.cnt;
        state_next = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        if (push_ready) begin
          push           = 1'b1;
          push_item.sym  = cur.sym;
          push_item.last = (rem <= CNT_W'(1)) && last_entry;
          push_item.drop = overflow_flag;
          rem_next       = rem - CNT_W'(1);
          if (rem <= CNT_W'(1)) begin
            if (last_entry) begin
              distinct_total_next = '0;
              length_seen_next    = '0;
              overflow_flag_next  = 1'b0;
              state_next          = ST_IDLE;
            end else begin
              idx_next   = idx_inc;
              state_next = ST_EMIT_LD;
            end
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distinct_total <= '0;
      length_seen    <= '0;
      overflow_flag  <= 1'b0;
      pend           <= 1'b0;
    end else begin
      distinct_total <= distinct_total_next;
      length_seen    <= length_seen_next;
      overflow_flag  <= overflow_flag_next;
      pend           <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    sym_q  <= sym_q_next;
    last_q <= last_q_next;
    rk     <= rk_next;
    ck     <= ck_next;
    idx    <= idx_next;
    cur    <= cur_next;
    rem    <= rem_next;
  end

endmodule

[rtl/frequency_sort_symbols.sv]
// Sorts the bytes of a string by occurrence count, ascending; ties settle as the exchange sort leaves them.
// Input channel s_*: one byte per item in s_tdata, s_tlast on the final byte.
// A zero byte is ignored; bytes past MAX_LEN are dropped and flagged.
// Output channel m_*: the sorted string, one byte per item, m_tlast on the last
// byte, m_tuser set on every byte when input was dropped.
// Each accepted byte is searched in a 64-entry table memory (one read per cycle,
// registered read data); the search runs over the D distinct symbols seen so
// far. The final byte then runs an exchange sort over the same memory, in outer
// passes over the entry positions, followed by emission of each distinct symbol
// as many times as it was counted. One string is handled at a time.
// s_tready is low while a byte is searched, and from the final byte until the
// last output item is registered. A string ending with no counted byte gives no output.
// Reset (rst, synchronous) clears the entry count, so the table reads as empty; no clearing pass is needed.
// When m_tready is low a held item stays in the output register and emission waits.
module frequency_sort_symbols import fss_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [SYM_W-1:0] s_tdata,   // symbol
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [SYM_W-1:0] m_tdata,   // out_symbol
  output logic             m_tlast,
  output logic             m_tuser    // dropped_input
);

  mem_req_t  mem_req;
  entry_t    rdata;
  logic      push;
  out_item_t push_item;
  logic      push_ready;

  fss_engine #(
    .MAX_LEN (MAX_LEN)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .mem_req    (mem_req),
    .rdata      (rdata),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  fss_table u_table (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  fss_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("item pushed into a full output register");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (push && push_item.last) |=> s_tready)
    else $error("input not reopened after last output item");

  a_no_zero_symbol: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_item.sym != '0))
    else $error("zero symbol emitted");

endmodule
